>>> rtl/core/assert_macros.svh
// Assertion macros used by the RTL of the heartbeat liveness monitor.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every clock edge, muted while reset is asserted.
`define HBLM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check a property at every clock edge, including during reset.
`define HBLM_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> rtl/core/hblm_pkg.sv
// Types and constants of the heartbeat liveness monitor.
package hblm_pkg;

	// Event codes of the input item
	localparam logic [1:0] OP_ACK   = 2'd0;
	localparam logic [1:0] OP_BEAT  = 2'd1;
	localparam logic [1:0] OP_START = 2'd2;
	localparam logic [1:0] OP_STOP  = 2'd3;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 32;
	localparam logic [CFG_IDX_W-1:0] REG_SESSION_ID    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HS_INTERVAL   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ST_INTERVAL   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HS_THRESHOLD  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ST_THRESHOLD  = 3'd4;

	// Register reset values
	localparam logic [31:0] RST_SESSION_ID   = 32'd0;
	localparam logic [15:0] RST_HS_INTERVAL  = 16'd200;
	localparam logic [15:0] RST_ST_INTERVAL  = 16'd1000;
	localparam logic [7:0]  RST_HS_THRESHOLD = 8'd10;
	localparam logic [7:0]  RST_ST_THRESHOLD = 8'd3;

	localparam logic [15:0] MISS_MAX = 16'hFFFF;

	typedef struct packed {
		logic [1:0]  op;
		logic [47:0] now_ms;
		logic [31:0] ack_session;
	} hblm_item_t;

	typedef struct packed {
		logic        send_heartbeat;
		logic        arm_timer;
		logic [15:0] next_interval_ms;
		logic        liveness_fail_event;
		logic        fail_latched;
		logic        is_associated;
		logic [15:0] miss_count;
		logic        ack_accepted;
		logic        ack_rejected;
	} hblm_result_t;

endpackage

>>> rtl/core/hblm_if.sv
// Valid/ready channel interfaces for monitor events and results.
interface hblm_item_if
	import hblm_pkg::*;
	;
	logic       valid;
	logic       ready;
	hblm_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface hblm_result_if
	import hblm_pkg::*;
	;
	logic         valid;
	logic         ready;
	hblm_result_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/heartbeat_liveness_monitor_top.sv
// Heartbeat liveness monitor: keepalive state machine with ack-miss detection.
//
//   channel  | direction | handshake     | payload
//   ---------+-----------+---------------+--------------------------------
//   item     | sink      | valid/ready   | op, now_ms, ack_session
//   result   | source    | valid/ready   | send_heartbeat ... ack_rejected
//   cfg      | sink      | cfg_we        | cfg_index, cfg_data
//
// Each item passes an input register, then the state update and result register.
// A new item transfers every cycle unless the result side stalls.
// The two-entry pipeline holds under stall on the result side; item ready
// drops only when both stages are full and the result is not taken.
// Reset clears the valid bits and monitor state and loads the register defaults; no clearing pass.
`include "assert_macros.svh"

module heartbeat_liveness_monitor_top
	import hblm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	hblm_item_if.sink            item,
	hblm_result_if.source        result,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// Configuration registers
	logic [31:0] session_id_q;
	logic [15:0] hs_interval_q;
	logic [15:0] st_interval_q;
	logic [7:0]  hs_threshold_q;
	logic [7:0]  st_threshold_q;

	// Monitor state
	logic        running_q;
	logic        halted_q;
	logic        assoc_q;
	logic        ack_since_q;
	logic [15:0] misses_q;
	logic        failed_q;
	logic [47:0] last_send_q;

	// Pipeline
	logic         valid_s1;
	hblm_item_t   item_s1;
	logic         valid_s2;
	hblm_result_t res_s2;
	logic         adv;

	// Next state and result
	logic         running_n;
	logic         halted_n;
	logic         assoc_n;
	logic         ack_since_n;
	logic [15:0]  misses_n;
	logic         failed_n;
	logic [47:0]  last_send_n;
	hblm_result_t res_n;

	// Advance stage one into the result register when that slot frees
	assign adv = valid_s1 && (!valid_s2 || result.ready);
	assign item.ready = !valid_s1 || adv;
	assign result.valid = valid_s2;
	assign result.data = res_s2;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			session_id_q   <= RST_SESSION_ID;
			hs_interval_q  <= RST_HS_INTERVAL;
			st_interval_q  <= RST_ST_INTERVAL;
			hs_threshold_q <= RST_HS_THRESHOLD;
			st_threshold_q <= RST_ST_THRESHOLD;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SESSION_ID:   session_id_q   <= cfg_data;
				REG_HS_INTERVAL:  hs_interval_q  <= cfg_data[15:0];
				REG_ST_INTERVAL:  st_interval_q  <= cfg_data[15:0];
				REG_HS_THRESHOLD: hs_threshold_q <= cfg_data[7:0];
				REG_ST_THRESHOLD: st_threshold_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Stage one: capture the transferred item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1 <= item.data;
		end
	end

	// Decode the event and update the monitor state
	always_comb begin
		logic        do_count;
		logic [7:0]  limit;
		logic [15:0] misses_inc;
		logic [47:0] age;

		running_n   = running_q;
		halted_n    = halted_q;
		assoc_n     = assoc_q;
		ack_since_n = ack_since_q;
		misses_n    = misses_q;
		failed_n    = failed_q;
		last_send_n = last_send_q;
		res_n       = '0;
		do_count    = 1'b0;
		limit       = hs_threshold_q;
		age         = item_s1.now_ms - last_send_q;
		misses_inc  = (misses_q == MISS_MAX) ? misses_q : misses_q + 16'd1;

		unique case (item_s1.op)
			OP_ACK: begin
				if (!halted_q) begin
					if (running_q && (session_id_q != '0) &&
					    (item_s1.ack_session == session_id_q)) begin
						assoc_n            = 1'b1;
						ack_since_n        = 1'b1;
						res_n.ack_accepted = 1'b1;
					end else begin
						res_n.ack_rejected = 1'b1;
					end
				end
			end
			OP_BEAT: begin
				if (running_q && !halted_q) begin
					res_n.arm_timer = 1'b1;
					if (assoc_q) begin
						res_n.next_interval_ms = st_interval_q;
						// Skip the beat when the last send is too recent
						if (age >= {32'd0, st_interval_q}) begin
							do_count             = 1'b1;
							limit                = st_threshold_q;
							res_n.send_heartbeat = 1'b1;
							last_send_n          = item_s1.now_ms;
						end
					end else begin
						res_n.next_interval_ms = hs_interval_q;
						do_count               = 1'b1;
						limit                  = hs_threshold_q;
						res_n.send_heartbeat   = 1'b1;
						last_send_n            = item_s1.now_ms;
					end
				end
			end
			OP_START: begin
				if ((session_id_q != '0) && (hs_interval_q != '0) &&
				    !halted_q && !running_q) begin
					running_n              = 1'b1;
					ack_since_n            = 1'b0;
					misses_n               = '0;
					failed_n               = 1'b0;
					last_send_n            = item_s1.now_ms;
					res_n.send_heartbeat   = 1'b1;
					res_n.arm_timer        = 1'b1;
					res_n.next_interval_ms = assoc_q ? st_interval_q : hs_interval_q;
				end
			end
			OP_STOP: begin
				halted_n  = 1'b1;
				running_n = 1'b0;
			end
			default: ;
		endcase

		// Count a miss, or clear the count after an accepted ack
		if (do_count) begin
			if (ack_since_q) begin
				ack_since_n = 1'b0;
				misses_n    = '0;
			end else begin
				misses_n = misses_inc;
				if (!failed_q && (misses_inc >= {8'd0, limit})) begin
					failed_n                  = 1'b1;
					res_n.liveness_fail_event = 1'b1;
				end
			end
		end

		res_n.fail_latched  = failed_n;
		res_n.is_associated = assoc_n;
		res_n.miss_count    = misses_n;
	end

	// Commit state as the item advances
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q   <= 1'b0;
			halted_q    <= 1'b0;
			assoc_q     <= 1'b0;
			ack_since_q <= 1'b0;
			misses_q    <= '0;
			failed_q    <= 1'b0;
			last_send_q <= '0;
		end else if (adv) begin
			running_q   <= running_n;
			halted_q    <= halted_n;
			assoc_q     <= assoc_n;
			ack_since_q <= ack_since_n;
			misses_q    <= misses_n;
			failed_q    <= failed_n;
			last_send_q <= last_send_n;
		end
	end

	// Stage two: hold the result until transferred
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || result.ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res_n;
		end
	end

	// Assertions
	`HBLM_ASSERT(a_run_halt_excl, !(running_q && halted_q), "running while halted")
	`HBLM_ASSERT(a_fail_event_latched, valid_s2 && res_s2.liveness_fail_event |-> res_s2.fail_latched, "fail event without latched failure")
	`HBLM_ASSERT(a_ack_verdict_excl, !(valid_s2 && res_s2.ack_accepted && res_s2.ack_rejected), "ack both accepted and rejected")
	`HBLM_ASSERT(a_assoc_from_ack, $rose(assoc_q) |-> $past(adv && (item_s1.op == OP_ACK)), "association set without an ack")

endmodule

>>> dv/heartbeat_liveness_monitor_top_tb.sv
// Self-checking testbench for the heartbeat liveness monitor top level.
`timescale 1ns / 100ps

module heartbeat_liveness_monitor_top_tb;
	import hblm_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int PHASE_ITEMS = 620;

	typedef struct {
		bit                    is_reg;
		logic [CFG_IDX_W-1:0]  reg_idx;
		logic [CFG_DATA_W-1:0] reg_val;
		hblm_item_t            ev;
		bit                    pinned;
		hblm_result_t          want;
	} step_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	hblm_item_if   item_ch();
	hblm_result_if result_ch();

	heartbeat_liveness_monitor_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_ch),
		.result    (result_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Predictor copy of the registers
	logic [31:0] m_session = RST_SESSION_ID;
	logic [15:0] m_hs_iv   = RST_HS_INTERVAL;
	logic [15:0] m_st_iv   = RST_ST_INTERVAL;
	logic [7:0]  m_hs_thr  = RST_HS_THRESHOLD;
	logic [7:0]  m_st_thr  = RST_ST_THRESHOLD;

	// Predictor copy of the keepalive state
	bit          m_running  = 1'b0;
	bit          m_halted   = 1'b0;
	bit          m_assoc    = 1'b0;
	bit          m_ack_seen = 1'b0;
	logic [15:0] m_misses   = '0;
	bit          m_failed   = 1'b0;
	logic [47:0] m_last_send = '0;

	hblm_result_t pending_responses[$];
	int           mismatches = 0;
	int           cycles = 0;
	int           src_idle_pct = 0;
	int           snk_idle_pct = 0;
	bit           pinned_on = 1'b0;
	hblm_result_t pinned_res;
	logic [47:0]  clock_ms = '0;
	step_row_t    opening_rows[$];
	step_row_t    closing_rows[$];

	// Clock: 20 ns period
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Count one beat against a threshold; true when the failure first latches
	function bit tally_miss(input logic [7:0] limit);
		if (m_ack_seen) begin
			m_ack_seen = 1'b0;
			m_misses = '0;
			return 1'b0;
		end
		if (m_misses != MISS_MAX)
			m_misses = m_misses + 16'd1;
		if (!m_failed && m_misses >= {8'd0, limit}) begin
			m_failed = 1'b1;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// Advance the predicted state by one event and return the block's response
	function hblm_result_t heartbeat_response(input hblm_item_t ev);
		hblm_result_t o;
		logic [47:0] age;
		o = '0;
		age = ev.now_ms - m_last_send;
		case (ev.op)
			OP_ACK: begin
				if (!m_halted) begin
					if (m_running && m_session != 0 && ev.ack_session == m_session) begin
						m_assoc = 1'b1;
						m_ack_seen = 1'b1;
						o.ack_accepted = 1'b1;
					end else begin
						o.ack_rejected = 1'b1;
					end
				end
			end
			OP_BEAT: begin
				if (m_running && !m_halted) begin
					if (m_assoc) begin
						// Skip the beat when the last send is less than one interval old
						if (age >= {32'd0, m_st_iv}) begin
							o.liveness_fail_event = tally_miss(m_st_thr);
							o.send_heartbeat = 1'b1;
							m_last_send = ev.now_ms;
						end
						o.next_interval_ms = m_st_iv;
					end else begin
						o.liveness_fail_event = tally_miss(m_hs_thr);
						o.send_heartbeat = 1'b1;
						m_last_send = ev.now_ms;
						o.next_interval_ms = m_hs_iv;
					end
					o.arm_timer = 1'b1;
				end
			end
			OP_START: begin
				if (m_session != 0 && m_hs_iv != 0 && !m_halted && !m_running) begin
					m_running = 1'b1;
					m_ack_seen = 1'b0;
					m_misses = '0;
					m_failed = 1'b0;
					m_last_send = ev.now_ms;
					o.send_heartbeat = 1'b1;
					o.arm_timer = 1'b1;
					o.next_interval_ms = m_assoc ? m_st_iv : m_hs_iv;
				end
			end
			OP_STOP: begin
				m_halted = 1'b1;
				m_running = 1'b0;
			end
		endcase
		o.fail_latched = m_failed;
		o.is_associated = m_assoc;
		o.miss_count = m_misses;
		return o;
	endfunction

	task automatic log_mismatch(input string msg);
		$display("ERROR @%0t: %s", $time, msg);
		mismatches++;
	endtask

	task automatic compare_field(input string name, input logic [47:0] got,
			input logic [47:0] want);
		if (got !== want)
			log_mismatch($sformatf("%s got %0h want %0h", name, got, want));
	endtask

	// Track register writes, predict on each item transfer, check each result transfer
	always @(posedge clk) begin
		hblm_result_t r;
		hblm_result_t w;
		hblm_result_t got;
		if (arst_n) begin
			if (cfg_we) begin
				case (cfg_index)
					REG_SESSION_ID:   m_session = cfg_data;
					REG_HS_INTERVAL:  m_hs_iv = cfg_data[15:0];
					REG_ST_INTERVAL:  m_st_iv = cfg_data[15:0];
					REG_HS_THRESHOLD: m_hs_thr = cfg_data[7:0];
					REG_ST_THRESHOLD: m_st_thr = cfg_data[7:0];
					default: ;
				endcase
			end
			if (item_ch.valid && item_ch.ready) begin
				r = heartbeat_response(item_ch.data);
				pending_responses.push_back(pinned_on ? pinned_res : r);
			end
			if (result_ch.valid && result_ch.ready) begin
				got = result_ch.data;
				if (pending_responses.size() == 0) begin
					log_mismatch("result with no outstanding expectation");
				end else begin
					w = pending_responses.pop_front();
					compare_field("send_heartbeat", got.send_heartbeat, w.send_heartbeat);
					compare_field("arm_timer", got.arm_timer, w.arm_timer);
					compare_field("next_interval_ms", got.next_interval_ms,
						w.next_interval_ms);
					compare_field("liveness_fail_event", got.liveness_fail_event,
						w.liveness_fail_event);
					compare_field("fail_latched", got.fail_latched, w.fail_latched);
					compare_field("is_associated", got.is_associated, w.is_associated);
					compare_field("miss_count", got.miss_count, w.miss_count);
					compare_field("ack_accepted", got.ack_accepted, w.ack_accepted);
					compare_field("ack_rejected", got.ack_rejected, w.ack_rejected);
				end
			end
		end
	end

	// Stall the result side at random
	always @(negedge clk) begin
		result_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycles = cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Hold one item on the channel until it transfers; returns at a falling edge
	task automatic drive_item(input hblm_item_t ev);
		while ($urandom_range(99) < src_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(negedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.data <= ev;
		do @(posedge clk); while (!item_ch.ready);
		@(negedge clk);
	endtask

	// Drop valid, wait for every expected result, then let the pipeline settle
	task automatic drain_block();
		item_ch.valid <= 1'b0;
		while (pending_responses.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	function automatic void add_item(ref step_row_t q[$], input logic [1:0] op,
			input logic [47:0] t, input logic [31:0] s, input bit pin = 1'b0,
			input hblm_result_t want = '0);
		step_row_t row;
		row = '{default: '0};
		row.ev = '{op: op, now_ms: t, ack_session: s};
		row.pinned = pin;
		row.want = want;
		q.push_back(row);
	endfunction

	function automatic void add_reg(ref step_row_t q[$], input logic [CFG_IDX_W-1:0] idx,
			input logic [31:0] val);
		step_row_t row;
		row = '{default: '0};
		row.is_reg = 1'b1;
		row.reg_idx = idx;
		row.reg_val = val;
		q.push_back(row);
	endfunction

	// Walk a table of register writes and items
	task automatic run_rows(ref step_row_t q[$]);
		foreach (q[i]) begin
			if (q[i].is_reg) begin
				drain_block();
				write_reg(q[i].reg_idx, q[i].reg_val);
			end else begin
				pinned_on = q[i].pinned;
				pinned_res = q[i].want;
				drive_item(q[i].ev);
				pinned_on = 1'b0;
			end
		end
	endtask

	// Random events around a moving clock; matching acks held back for the first items
	task automatic random_burst(input int count, input int hold_match);
		hblm_item_t ev;
		int pick;
		int cur_iv;
		logic [63:0] jump;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(99);
			if (pick < 55)
				ev.op = OP_BEAT;
			else if (pick < 92)
				ev.op = OP_ACK;
			else
				ev.op = OP_START;
			// Advance time by up to two intervals, or jump anywhere now and then
			cur_iv = m_assoc ? int'(m_st_iv) : int'(m_hs_iv);
			if ($urandom_range(99) < 5) begin
				jump = {$urandom(), $urandom()};
				clock_ms = jump[47:0];
			end else begin
				clock_ms = clock_ms + 48'($urandom_range(2 * cur_iv));
			end
			ev.now_ms = clock_ms;
			pick = $urandom_range(9);
			if (pick < 5 && n >= hold_match)
				ev.ack_session = m_session;
			else if (pick < 7 || pick < 5)
				ev.ack_session = m_session ^ (32'd1 << $urandom_range(31));
			else if (pick == 7)
				ev.ack_session = '0;
			else
				ev.ack_session = $urandom();
			drive_item(ev);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		item_ch.valid = 1'b0;
		item_ch.data = '0;
		result_ch.ready = 1'b0;

		// Opening table: idle rejects, start extremes, handshake misses up to failure
		add_item(opening_rows, OP_ACK, 48'd0, 32'd0, 1'b1,
			'{1'b0, 1'b0, 16'd0, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0, 1'b1});
		add_item(opening_rows, OP_BEAT, 48'd0, 32'd0, 1'b1, '0);
		add_item(opening_rows, OP_START, 48'd0, 32'd0, 1'b1, '0);
		add_reg(opening_rows, REG_SESSION_ID, 32'hFFFF_FFFF);
		add_reg(opening_rows, REG_HS_INTERVAL, 32'd65535);
		add_reg(opening_rows, REG_HS_THRESHOLD, 32'd3);
		add_item(opening_rows, OP_ACK, 48'd0, 32'hFFFF_FFFF, 1'b1,
			'{1'b0, 1'b0, 16'd0, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0, 1'b1});
		add_item(opening_rows, OP_START, 48'hFFFF_FFFF_FFF0, 32'd0, 1'b1,
			'{1'b1, 1'b1, 16'hFFFF, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0, 1'b0});
		add_item(opening_rows, OP_START, 48'hFFFF_FFFF_FFF1, 32'd0, 1'b1, '0);
		add_item(opening_rows, OP_BEAT, 48'hFFFF_FFFF_FFF2, 32'd0, 1'b1,
			'{1'b1, 1'b1, 16'hFFFF, 1'b0, 1'b0, 1'b0, 16'd1, 1'b0, 1'b0});
		add_item(opening_rows, OP_ACK, 48'hFFFF_FFFF_FFF3, 32'd0, 1'b1,
			'{1'b0, 1'b0, 16'd0, 1'b0, 1'b0, 1'b0, 16'd1, 1'b0, 1'b1});
		add_item(opening_rows, OP_ACK, 48'hFFFF_FFFF_FFF3, 32'h7FFF_FFFF);
		add_item(opening_rows, OP_BEAT, 48'hFFFF_FFFF_FFF4, 32'd0);
		add_item(opening_rows, OP_BEAT, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
			'{1'b1, 1'b1, 16'hFFFF, 1'b1, 1'b1, 1'b0, 16'd3, 1'b0, 1'b0});
		add_item(opening_rows, OP_BEAT, 48'd0, 32'd0);

		// Closing table: steady skip across the time wrap, ack clear, then stop
		add_reg(closing_rows, REG_ST_INTERVAL, 32'd65535);
		add_item(closing_rows, OP_BEAT, 48'hFFFF_FFFF_FFF0, 32'd0);
		add_item(closing_rows, OP_BEAT, 48'h0000_0000_0005, 32'd0);
		add_item(closing_rows, OP_BEAT, 48'h0000_0001_0000, 32'd0);
		add_item(closing_rows, OP_ACK, 48'h0000_0001_0001, 32'd1);
		add_item(closing_rows, OP_BEAT, 48'h0000_0002_0000, 32'd0);
		add_item(closing_rows, OP_STOP, 48'h0000_0002_0001, 32'd0);
		add_item(closing_rows, OP_ACK, 48'h0000_0002_0002, 32'd1);
		add_item(closing_rows, OP_BEAT, 48'h0000_0003_0000, 32'd0);
		add_item(closing_rows, OP_START, 48'h0000_0003_0001, 32'd0);
		add_item(closing_rows, OP_STOP, 48'h0000_0003_0002, 32'd0);

		// Hold reset, then release it
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Sender idles lightly, receiver stalls heavily
		src_idle_pct = 8;
		snk_idle_pct = 84;
		run_rows(opening_rows);

		// Handshake at the shortest interval, then association at the longest steady interval
		drain_block();
		write_reg(REG_HS_INTERVAL, 32'd1);
		write_reg(REG_HS_THRESHOLD, 32'd255);
		write_reg(REG_ST_INTERVAL, 32'd65535);
		write_reg(REG_ST_THRESHOLD, 32'd255);
		random_burst(PHASE_ITEMS, 200);

		// Swap the idling sides; new session, shortest steady interval
		drain_block();
		src_idle_pct = 84;
		snk_idle_pct = 8;
		write_reg(REG_SESSION_ID, $urandom() | 32'h1);
		write_reg(REG_HS_INTERVAL, 32'($urandom_range(65535, 1)));
		write_reg(REG_ST_INTERVAL, 32'd1);
		write_reg(REG_ST_THRESHOLD, 32'd1);
		random_burst(PHASE_ITEMS, 0);

		// No idling; mid-range settings
		drain_block();
		src_idle_pct = 0;
		snk_idle_pct = 0;
		write_reg(REG_SESSION_ID, 32'd1);
		write_reg(REG_HS_THRESHOLD, 32'd1);
		write_reg(REG_ST_INTERVAL, 32'($urandom_range(5000, 2)));
		write_reg(REG_ST_THRESHOLD, 32'($urandom_range(255, 1)));
		random_burst(PHASE_ITEMS, 0);

		run_rows(closing_rows);
		drain_block();

		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/hblm_pkg.sv
rtl/core/hblm_if.sv
rtl/core/heartbeat_liveness_monitor_top.sv
dv/heartbeat_liveness_monitor_top_tb.sv
